[design/ipts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipts_pkg: shared types and constants for the idle timeout power state block
// Request and result payloads, configuration bundle, state and register codes.
// ----------------------------------------------------------------------------
package ipts_pkg;

    // Configuration port geometry: five 32-bit registers at 4-byte spacing
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BRT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_BRT     = 3'd4;

    // Field widths
    localparam int HOLD_W   = 16;
    localparam int MIN_W    = 11;
    localparam int BRT_W    = 7;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 8;
    localparam int STATE_W  = 2;
    // Minutes times 60000 fits in 27 bits for any 11-bit minute count
    localparam int THR_W    = MIN_W + 16;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    // Reset values
    localparam logic [HOLD_W-1:0] RST_ACTIVE_HOLD = 16'd10000;
    localparam logic [MIN_W-1:0]  RST_DIM_MIN     = 11'd1;
    localparam logic [MIN_W-1:0]  RST_OFF_MIN     = 11'd5;
    localparam logic [THR_W-1:0]  RST_DIM_MS      = 27'd60000;
    localparam logic [THR_W-1:0]  RST_OFF_MS      = 27'd300000;
    localparam logic [BRT_W-1:0]  RST_NORMAL_BRT  = 7'd80;
    localparam logic [BRT_W-1:0]  RST_DIM_BRT     = 7'd20;

    // Power state codes
    localparam logic [STATE_W-1:0] ST_ACTIVE = 2'd0;
    localparam logic [STATE_W-1:0] ST_IDLE   = 2'd1;
    localparam logic [STATE_W-1:0] ST_DIM    = 2'd2;
    localparam logic [STATE_W-1:0] ST_OFF    = 2'd3;

    // Request kinds
    localparam logic ACT_ACTIVITY = 1'b0;
    localparam logic ACT_UPDATE   = 1'b1;

    // Per-state settings
    localparam logic [BRT_W-1:0]    BRT_FULL      = 7'd100;
    localparam logic [BRT_W-1:0]    BRT_NONE      = 7'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_ACTIVE = 8'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_IDLE   = 8'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_SLEEP  = 8'd200;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_ms;
        logic              is_touch;
        logic              busy_req;
        logic              alarm;
        logic              hold_display;
    } req_item_t;

    typedef struct packed {
        logic [STATE_W-1:0]  power_state;
        logic [BRT_W-1:0]    brightness;
        logic                scan_continuous;
        logic [PERIOD_W-1:0] sensor_period_ms;
        logic                speaker_on;
        logic                touch_discard;
    } res_item_t;

    // Configuration as seen by the datapath; thresholds already in ms
    typedef struct packed {
        logic [HOLD_W-1:0] active_hold_ms;
        logic [THR_W-1:0]  dim_ms;
        logic [THR_W-1:0]  off_ms;
        logic [BRT_W-1:0]  normal_brightness;
        logic [BRT_W-1:0]  dim_brightness;
    } cfg_t;

endpackage
`default_nettype wire

[design/ipts_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipts_cfg: configuration register file
// APB-style registers; minute thresholds are scaled to ms as they are written.
// ----------------------------------------------------------------------------
module ipts_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ipts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [ipts_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [ipts_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output ipts_pkg::cfg_t                        cfg
);

    logic [ipts_pkg::CFG_IDX_W-1:0] idx;
    logic                           wr_en;
    logic [ipts_pkg::THR_W-1:0]     wr_ms;

    logic [ipts_pkg::HOLD_W-1:0] active_hold_reg;
    logic [ipts_pkg::MIN_W-1:0]  dim_min_reg;
    logic [ipts_pkg::MIN_W-1:0]  off_min_reg;
    logic [ipts_pkg::THR_W-1:0]  dim_ms_reg;
    logic [ipts_pkg::THR_W-1:0]  off_ms_reg;
    logic [ipts_pkg::BRT_W-1:0]  normal_brt_reg;
    logic [ipts_pkg::BRT_W-1:0]  dim_brt_reg;

    assign pready = 1'b1;
    assign idx    = paddr[ipts_pkg::CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    // One shared multiplier scales the written minute count
    assign wr_ms  = ipts_pkg::THR_W'(pwdata[ipts_pkg::MIN_W-1:0])
                  * ipts_pkg::THR_W'(ipts_pkg::MS_PER_MINUTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_hold_reg <= ipts_pkg::RST_ACTIVE_HOLD;
            dim_min_reg     <= ipts_pkg::RST_DIM_MIN;
            off_min_reg     <= ipts_pkg::RST_OFF_MIN;
            dim_ms_reg      <= ipts_pkg::RST_DIM_MS;
            off_ms_reg      <= ipts_pkg::RST_OFF_MS;
            normal_brt_reg  <= ipts_pkg::RST_NORMAL_BRT;
            dim_brt_reg     <= ipts_pkg::RST_DIM_BRT;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ipts_pkg::REG_ACTIVE_HOLD:
                begin
                    active_hold_reg <= pwdata[ipts_pkg::HOLD_W-1:0];
                end
                ipts_pkg::REG_DIM_MIN:
                begin
                    dim_min_reg <= pwdata[ipts_pkg::MIN_W-1:0];
                    dim_ms_reg  <= wr_ms;
                end
                ipts_pkg::REG_OFF_MIN:
                begin
                    off_min_reg <= pwdata[ipts_pkg::MIN_W-1:0];
                    off_ms_reg  <= wr_ms;
                end
                ipts_pkg::REG_NORMAL_BRT:
                begin
                    normal_brt_reg <= pwdata[ipts_pkg::BRT_W-1:0];
                end
                ipts_pkg::REG_DIM_BRT:
                begin
                    dim_brt_reg <= pwdata[ipts_pkg::BRT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ipts_pkg::REG_ACTIVE_HOLD: prdata = ipts_pkg::CFG_DATA_W'(active_hold_reg);
            ipts_pkg::REG_DIM_MIN:     prdata = ipts_pkg::CFG_DATA_W'(dim_min_reg);
            ipts_pkg::REG_OFF_MIN:     prdata = ipts_pkg::CFG_DATA_W'(off_min_reg);
            ipts_pkg::REG_NORMAL_BRT:  prdata = ipts_pkg::CFG_DATA_W'(normal_brt_reg);
            ipts_pkg::REG_DIM_BRT:     prdata = ipts_pkg::CFG_DATA_W'(dim_brt_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.active_hold_ms    = active_hold_reg;
    assign cfg.dim_ms            = dim_ms_reg;
    assign cfg.off_ms            = off_ms_reg;
    assign cfg.normal_brightness = normal_brt_reg;
    assign cfg.dim_brightness    = dim_brt_reg;

endmodule
`default_nettype wire

[design/ipts_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipts_core: request register, power state decision and result register
// Holds last activity time and state; one request per cycle when not stalled.
// ----------------------------------------------------------------------------
module ipts_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ipts_pkg::cfg_t cfg,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ipts_pkg::req_item_t req_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output ipts_pkg::res_item_t res_data
);

    logic                       in_vld_reg;
    ipts_pkg::req_item_t        in_reg;
    logic                       out_vld_reg;
    ipts_pkg::res_item_t        out_reg;
    logic [ipts_pkg::TIME_W-1:0]  last_reg;
    logic [ipts_pkg::STATE_W-1:0] state_reg;

    logic                         adv;
    logic [ipts_pkg::TIME_W-1:0]  idle_ms;
    logic [ipts_pkg::STATE_W-1:0] picked;
    logic [ipts_pkg::STATE_W-1:0] state_next;
    logic [ipts_pkg::TIME_W-1:0]  last_next;
    logic                         alarm_eff;
    logic                         swallow;
    ipts_pkg::res_item_t          res_next;

    assign adv       = in_vld_reg && (!out_vld_reg || !res_stall);
    assign req_stall = in_vld_reg && !adv;
    assign res_valid = out_vld_reg;
    assign res_data  = out_reg;

    // Wrap-safe elapsed time since the last activity
    assign idle_ms = in_reg.now_ms - last_reg;

    always_comb
    begin
        if (idle_ms < ipts_pkg::TIME_W'(cfg.active_hold_ms))
        begin
            picked = ipts_pkg::ST_ACTIVE;
        end
        else if (cfg.off_ms != '0 && idle_ms >= ipts_pkg::TIME_W'(cfg.off_ms))
        begin
            picked = in_reg.hold_display ? ipts_pkg::ST_DIM : ipts_pkg::ST_OFF;
        end
        else if (cfg.dim_ms != '0 && idle_ms >= ipts_pkg::TIME_W'(cfg.dim_ms))
        begin
            picked = ipts_pkg::ST_DIM;
        end
        else
        begin
            picked = ipts_pkg::ST_IDLE;
        end
    end

    always_comb
    begin
        state_next = picked;
        last_next  = last_reg;
        alarm_eff  = 1'b0;
        swallow    = 1'b0;
        if (in_reg.action == ipts_pkg::ACT_ACTIVITY)
        begin
            swallow    = in_reg.is_touch
                      && (state_reg == ipts_pkg::ST_DIM || state_reg == ipts_pkg::ST_OFF);
            state_next = ipts_pkg::ST_ACTIVE;
            last_next  = in_reg.now_ms;
        end
        else if (in_reg.busy_req || in_reg.alarm)
        begin
            alarm_eff  = in_reg.alarm;
            state_next = ipts_pkg::ST_ACTIVE;
            last_next  = in_reg.now_ms;
        end
    end

    always_comb
    begin
        res_next.power_state   = state_next;
        res_next.touch_discard = swallow;
        unique case (state_next)
            ipts_pkg::ST_ACTIVE:
            begin
                res_next.brightness       = alarm_eff ? ipts_pkg::BRT_FULL
                                                      : cfg.normal_brightness;
                res_next.scan_continuous  = 1'b1;
                res_next.sensor_period_ms = ipts_pkg::PERIOD_ACTIVE;
                res_next.speaker_on       = 1'b1;
            end
            ipts_pkg::ST_IDLE:
            begin
                res_next.brightness       = cfg.normal_brightness;
                res_next.scan_continuous  = 1'b1;
                res_next.sensor_period_ms = ipts_pkg::PERIOD_IDLE;
                res_next.speaker_on       = 1'b0;
            end
            ipts_pkg::ST_DIM:
            begin
                res_next.brightness       = cfg.dim_brightness;
                res_next.scan_continuous  = 1'b0;
                res_next.sensor_period_ms = ipts_pkg::PERIOD_SLEEP;
                res_next.speaker_on       = 1'b0;
            end
            default:
            begin
                res_next.brightness       = ipts_pkg::BRT_NONE;
                res_next.scan_continuous  = 1'b0;
                res_next.sensor_period_ms = ipts_pkg::PERIOD_SLEEP;
                res_next.speaker_on       = 1'b0;
            end
        endcase
    end

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req_valid && !req_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_reg <= req_data;
        end
    end

    // Result register and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            last_reg    <= '0;
            state_reg   <= ipts_pkg::ST_ACTIVE;
        end
        else if (adv)
        begin
            out_vld_reg <= 1'b1;
            last_reg    <= last_next;
            state_reg   <= state_next;
        end
        else if (!res_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

[design/idle_timeout_power_state.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idle_timeout_power_state: inactivity timer with active/idle/dim/off states
// Tracks user activity against a millisecond clock and reports device settings.
// ----------------------------------------------------------------------------
// Each request is either a user-activity event (action 0) or a periodic update
// (action 1) carrying a free-running 32-bit millisecond timestamp. Activity,
// or an update with busy or alarm set, restarts the inactivity timer and
// forces the active state; other updates compare the wrap-safe elapsed time
// with the active hold time and the off and dim thresholds (off tested first,
// zero minutes disables a threshold, hold_display turns off into dim). Every
// request yields exactly one result with the new state and its brightness,
// scanner, sensor period and speaker settings; a touch that wakes a dim or off
// display is flagged for discard. The block takes one request per clock while
// the result side is not stalled: the request lands in an input register, the
// compare logic decides the state and fills the result register, which holds
// while res_stall is high; results drain at one per cycle when not stalled.
// The cycle is set by the 32-bit elapsed-time subtract feeding the threshold
// compares; threshold minutes are scaled to milliseconds once, when the
// register is written.
// Configure only while no request is in flight.
module idle_timeout_power_state (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ipts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [ipts_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [ipts_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    // Request channel
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire ipts_pkg::req_item_t              req_data,
    // Result channel
    output logic                                  res_valid,
    input  wire logic                             res_stall,
    output ipts_pkg::res_item_t                   res_data
);

    ipts_pkg::cfg_t cfg;

    // Register file: holds settings, scales minute thresholds on write
    ipts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decision pipeline: request register, state logic, result register
    ipts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire

[sim/idle_timeout_power_state_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_timeout_power_state_tb: self-checking bench for the power state block
// Drives activity events and timed updates through the request channel,
// reprograms the timeout and brightness registers between phases, and
// checks every result against an in-bench model of the inactivity timer.
// ----------------------------------------------------------------------------
import ipts_pkg::*;

// Tracks the timer state and register copy, and queues the expected settings.
class power_settings_tracker;
    localparam logic [31:0] MINUTE_MS = 32'd60000;

    logic [15:0] hold_ms;
    logic [10:0] dim_min;
    logic [10:0] off_min;
    logic [6:0]  normal_brt;
    logic [6:0]  dim_brt;
    logic [31:0] last_activity;
    logic [1:0]  state;
    res_item_t   settings_due[$];
    int          errors;
    int          results_seen;

    function new();
        hold_ms       = 16'd10000;
        dim_min       = 11'd1;
        off_min       = 11'd5;
        normal_brt    = 7'd80;
        dim_brt       = 7'd20;
        last_activity = '0;
        state         = ST_ACTIVE;
        errors        = 0;
        results_seen  = 0;
    endfunction

    function void write_register(int idx, logic [31:0] value);
        case (idx)
            REG_ACTIVE_HOLD: hold_ms    = value[15:0];
            REG_DIM_MIN:     dim_min    = value[10:0];
            REG_OFF_MIN:     off_min    = value[10:0];
            REG_NORMAL_BRT:  normal_brt = value[6:0];
            REG_DIM_BRT:     dim_brt    = value[6:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] minutes_to_ms(logic [10:0] minutes);
        return 32'(minutes) * MINUTE_MS;
    endfunction

    function int pending();
        return settings_due.size();
    endfunction

    // Off is tested ahead of dim; a held display stays dim instead of off.
    function logic [1:0] idle_state(logic [31:0] idle, logic keep);
        if (idle < 32'(hold_ms))
            return ST_ACTIVE;
        if (off_min != 0 && idle >= minutes_to_ms(off_min))
            return keep ? ST_DIM : ST_OFF;
        if (dim_min != 0 && idle >= minutes_to_ms(dim_min))
            return ST_DIM;
        return ST_IDLE;
    endfunction

    function void take_request(req_item_t r);
        res_item_t  want;
        logic       full_bright;
        logic       swallow;
        full_bright = 1'b0;
        swallow     = 1'b0;
        if (r.action == ACT_ACTIVITY) begin
            swallow       = r.is_touch && (state == ST_DIM || state == ST_OFF);
            last_activity = r.now_ms;
            state         = ST_ACTIVE;
        end else if (r.busy_req || r.alarm) begin
            last_activity = r.now_ms;
            state         = ST_ACTIVE;
            full_bright   = r.alarm;
        end else begin
            state = idle_state(r.now_ms - last_activity, r.hold_display);
        end
        want.power_state   = state;
        want.touch_discard = swallow;
        case (state)
            ST_ACTIVE: begin
                want.brightness       = full_bright ? 7'd100 : normal_brt;
                want.scan_continuous  = 1'b1;
                want.sensor_period_ms = 8'd50;
                want.speaker_on       = 1'b1;
            end
            ST_IDLE: begin
                want.brightness       = normal_brt;
                want.scan_continuous  = 1'b1;
                want.sensor_period_ms = 8'd100;
                want.speaker_on       = 1'b0;
            end
            ST_DIM: begin
                want.brightness       = dim_brt;
                want.scan_continuous  = 1'b0;
                want.sensor_period_ms = 8'd200;
                want.speaker_on       = 1'b0;
            end
            default: begin
                want.brightness       = 7'd0;
                want.scan_continuous  = 1'b0;
                want.sensor_period_ms = 8'd200;
                want.speaker_on       = 1'b0;
            end
        endcase
        settings_due.push_back(want);
    endfunction

    task report_mismatch(string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        errors++;
    endtask

    task compare_field(string field, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    task check_settings(res_item_t got);
        res_item_t want;
        if (settings_due.size() == 0) begin
            report_mismatch("result with no request outstanding");
        end else begin
            want = settings_due.pop_front();
            compare_field("power_state", got.power_state, want.power_state);
            compare_field("brightness", got.brightness, want.brightness);
            compare_field("scan_continuous", got.scan_continuous, want.scan_continuous);
            compare_field("sensor_period_ms", got.sensor_period_ms, want.sensor_period_ms);
            compare_field("speaker_on", got.speaker_on, want.speaker_on);
            compare_field("touch_discard", got.touch_discard, want.touch_discard);
        end
        results_seen++;
    endtask
endclass

module idle_timeout_power_state_tb;

    // Margin after the last result before the registers are reprogrammed.
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 10;
    localparam int PHASE_REQUESTS = 190;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req_data;
    logic                  res_valid;
    logic                  res_stall;
    res_item_t             res_data;

    power_settings_tracker tracker;
    bit                    no_gaps;
    bit                    moved;
    int                    quiet_cycles;

    idle_timeout_power_state uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_item_t build_request(logic action, logic [31:0] now_ms,
                                                logic touch, logic busy,
                                                logic alarm, logic hold);
        req_item_t r;
        r.action       = action;
        r.now_ms       = now_ms;
        r.is_touch     = touch;
        r.busy_req     = busy;
        r.alarm        = alarm;
        r.hold_display = hold;
        return r;
    endfunction

    // Aim timestamps at the hold and minute thresholds measured from the
    // last activity, so every state and each boundary gets visited.
    function automatic req_item_t random_request();
        req_item_t   r;
        logic [31:0] thr;
        logic [31:0] span;
        int          roll;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       thr = 32'(tracker.hold_ms);
            1:       thr = tracker.minutes_to_ms(tracker.dim_min);
            default: thr = tracker.minutes_to_ms(tracker.off_min);
        endcase
        span = tracker.minutes_to_ms(tracker.off_min > tracker.dim_min ?
                                     tracker.off_min : tracker.dim_min);
        if (span < 32'(tracker.hold_ms))
            span = 32'(tracker.hold_ms);
        span = span + span / 4 + 1;
        r = build_request(ACT_UPDATE, $urandom, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                          1'($urandom_range(0, 1)));
        if (roll < 20) begin
            r.action = ACT_ACTIVITY;
            r.busy_req = 1'($urandom_range(0, 1));
            r.alarm    = 1'($urandom_range(0, 1));
            if (roll < 17)
                r.now_ms = tracker.last_activity + $urandom_range(0, span);
        end else if (roll < 50) begin
            r.now_ms = tracker.last_activity + thr + 32'($urandom_range(0, 2)) - 32'd1;
        end else if (roll < 90) begin
            r.now_ms = tracker.last_activity + $urandom_range(0, span);
        end
        return r;
    endfunction

    // Enter at a falling edge, leave at the falling edge after acceptance.
    // Valid stays high when the next request follows with no gap.
    task automatic send_request(input req_item_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Setup then access phase; pready is sampled at the rising edge.
    // The bus goes idle before the task returns so back-to-back writes never collide.
    task automatic cfg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_register(idx, value);
        @(negedge clk);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe empty.
    task automatic settle();
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_phase(input int phase);
        case (phase)
            1: begin
                // every threshold disabled, zero hold: idle right away
                cfg_write(REG_ACTIVE_HOLD, 32'd0);
                cfg_write(REG_DIM_MIN, 32'd0);
                cfg_write(REG_OFF_MIN, 32'd0);
            end
            2: begin
                cfg_write(REG_ACTIVE_HOLD, 32'd65535);
                cfg_write(REG_DIM_MIN, 32'd2047);
                cfg_write(REG_OFF_MIN, 32'd2047);
                cfg_write(REG_NORMAL_BRT, 32'd127);
                cfg_write(REG_DIM_BRT, 32'd127);
            end
            3: begin
                // equal thresholds: off must win over dim
                cfg_write(REG_ACTIVE_HOLD, 32'd1);
                cfg_write(REG_DIM_MIN, 32'd1);
                cfg_write(REG_OFF_MIN, 32'd1);
                cfg_write(REG_NORMAL_BRT, 32'd0);
                cfg_write(REG_DIM_BRT, 32'd0);
            end
            4: begin
                // dim threshold beyond off, so dim is never reached on its own
                cfg_write(REG_ACTIVE_HOLD, 32'd10000);
                cfg_write(REG_DIM_MIN, 32'd5);
                cfg_write(REG_OFF_MIN, 32'd2);
                cfg_write(REG_NORMAL_BRT, 32'd100);
                cfg_write(REG_DIM_BRT, 32'd100);
            end
            5: begin
                // upper bits must be dropped by every register
                cfg_write(REG_ACTIVE_HOLD, 32'hFFFF_FFFF);
                cfg_write(REG_DIM_MIN, 32'hFFFF_FFFF);
                cfg_write(REG_OFF_MIN, 32'hFFFF_FFFF);
                cfg_write(REG_NORMAL_BRT, 32'hFFFF_FFFF);
                cfg_write(REG_DIM_BRT, 32'hFFFF_FFFF);
            end
            default: begin
                cfg_write(REG_ACTIVE_HOLD, $urandom_range(0, 3) == 0 ? $urandom
                                                                     : $urandom_range(0, 65535));
                cfg_write(REG_DIM_MIN, $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 1440));
                cfg_write(REG_OFF_MIN, $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 1440));
                cfg_write(REG_NORMAL_BRT, $urandom_range(0, 3) == 0 ? $urandom
                                                                    : $urandom_range(0, 100));
                cfg_write(REG_DIM_BRT, $urandom_range(0, 100));
            end
        endcase
        // Writes to unused register slots must leave everything untouched.
        for (int k = REG_DIM_BRT + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(k, $urandom);
    endtask

    // Result side: stall in random bursts, with stall-free stretches.
    initial
    begin
        int run_len;
        int gap;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run_len = $urandom_range(1, 24);
            res_stall <= 1'b0;
            repeat (run_len) @(negedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
        end
    end

    // Sample both handshakes at the rising edge; feed the tracker in order
    // and trip the watchdog when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            moved = 1'b0;
            if (req_valid && !req_stall) begin
                tracker.take_request(req_data);
                moved = 1'b1;
            end
            if (res_valid && !res_stall) begin
                tracker.check_settings(res_data);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        tracker      = new();
        no_gaps      = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        req_data     = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk through the reset thresholds: hold 10 s, dim 1 min,
        // off 5 min, timer starting at zero.
        send_request(build_request(ACT_UPDATE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'd9999, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'd10000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'd59999, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'd60000, 1'b0, 1'b0, 1'b0, 1'b0));
        // touch while dim is swallowed and wakes the display
        send_request(build_request(ACT_ACTIVITY, 32'd60001, 1'b1, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'd360000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'd360001, 1'b0, 1'b0, 1'b0, 1'b0));
        // held display stays dim past the off threshold
        send_request(build_request(ACT_UPDATE, 32'd360001, 1'b0, 1'b0, 1'b0, 1'b1));
        send_request(build_request(ACT_UPDATE, 32'd360001, 1'b0, 1'b0, 1'b0, 1'b0));
        // touch while off, with update-only flags set that must be ignored
        send_request(build_request(ACT_ACTIVITY, 32'd360002, 1'b1, 1'b1, 1'b1, 1'b1));
        // touch while already active is not swallowed
        send_request(build_request(ACT_ACTIVITY, 32'd360003, 1'b1, 1'b0, 1'b0, 1'b0));
        // alarm forces full brightness and restarts the timer
        send_request(build_request(ACT_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0));
        // timestamp wrapped past zero, elapsed stays small; touch ignored
        send_request(build_request(ACT_UPDATE, 32'h0000_0100, 1'b1, 1'b0, 1'b0, 1'b1));
        send_request(build_request(ACT_UPDATE, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0));
        // clock stepping backward looks like a huge elapsed time
        send_request(build_request(ACT_UPDATE, 32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_ACTIVITY, 32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_UPDATE, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b1));
        send_request(build_request(ACT_UPDATE, 32'h8000_EA60, 1'b1, 1'b0, 1'b0, 1'b1));
        send_request(build_request(ACT_UPDATE, 32'h8004_93E0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_request(build_request(ACT_UPDATE, 32'h8004_93E0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_request(build_request(ACT_ACTIVITY, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0));

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                program_phase(phase);
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_request(random_request());
            end
        end
        no_gaps = 1'b0;

        settle();
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/ipts_pkg.sv
design/ipts_cfg.sv
design/ipts_core.sv
design/idle_timeout_power_state.sv
sim/idle_timeout_power_state_tb.sv
